[rtl/otfl_pkg.sv]
// shared types, codes and microprogram for the object table free list
package otfl_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int SLOT_LIMIT      = 256;
  localparam int REF_W           = 64;
  localparam int SLOT_W          = 8;
  localparam int COUNT_W         = 9;
  localparam int PC_W            = 4;

  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_REMOVE   = 2'd1;
  localparam logic [1:0] OP_LOOKUP   = 2'd2;
  localparam logic [1:0] OP_CONTAINS = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // address select
  localparam logic [1:0] A_HEAD = 2'd0;
  localparam logic [1:0] A_SLOT = 2'd1;
  localparam logic [1:0] A_USED = 2'd2;
  localparam logic [1:0] A_SCAN = 2'd3;

  // write data select
  localparam logic W_REF  = 1'b0;
  localparam logic W_HEAD = 1'b1;

  // register actions
  localparam logic [1:0] ACT_NONE     = 2'd0;
  localparam logic [1:0] ACT_POP      = 2'd1;
  localparam logic [1:0] ACT_PUSH     = 2'd2;
  localparam logic [1:0] ACT_INC_USED = 2'd3;

  // result updates
  localparam logic [2:0] RES_NONE      = 3'd0;
  localparam logic [2:0] RES_SLOT_HEAD = 3'd1;
  localparam logic [2:0] RES_SLOT_USED = 3'd2;
  localparam logic [2:0] RES_WORD      = 3'd3;
  localparam logic [2:0] RES_FULL      = 3'd4;
  localparam logic [2:0] RES_BAD       = 3'd5;
  localparam logic [2:0] RES_MATCH     = 3'd6;

  // jump conditions
  localparam logic [2:0] C_NEVER     = 3'd0;
  localparam logic [2:0] C_HEAD_ZERO = 3'd1;
  localparam logic [2:0] C_FULL      = 3'd2;
  localparam logic [2:0] C_BAD       = 3'd3;
  localparam logic [2:0] C_SKIP      = 3'd4;
  localparam logic [2:0] C_MORE      = 3'd5;

  // program entry points and shared steps
  localparam logic [PC_W-1:0] PC_ADD      = 4'd1;
  localparam logic [PC_W-1:0] PC_ADD_NEW  = 4'd3;
  localparam logic [PC_W-1:0] PC_FULL     = 4'd5;
  localparam logic [PC_W-1:0] PC_REMOVE   = 4'd6;
  localparam logic [PC_W-1:0] PC_BAD      = 4'd8;
  localparam logic [PC_W-1:0] PC_LOOKUP   = 4'd9;
  localparam logic [PC_W-1:0] PC_CONTAINS = 4'd11;
  localparam logic [PC_W-1:0] PC_SCAN     = 4'd13;
  localparam logic [PC_W-1:0] PC_FINISH   = 4'd14;

  typedef struct packed {
    logic [1:0]      asel;
    logic            rd;
    logic            wr;
    logic            wsel;
    logic [1:0]      act;
    logic            scan_inc;
    logic [2:0]      res;
    logic            done;
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
  } ctl_t;

  typedef struct packed {
    logic head_zero;
    logic full;
    logic bad;
    logic skip;
    logic more;
  } flags_t;

  function automatic logic [PC_W-1:0] entry_pc(input logic [1:0] op);
    logic [PC_W-1:0] pc;
    case (op)
      OP_ADD:    pc = PC_ADD;
      OP_REMOVE: pc = PC_REMOVE;
      OP_LOOKUP: pc = PC_LOOKUP;
      default:   pc = PC_CONTAINS;
    endcase
    return pc;
  endfunction

  function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
    ctl_t c;
    c = '0;
    case (pc)
      4'd1: begin
        c.asel = A_HEAD; c.rd = 1'b1; c.cond = C_HEAD_ZERO; c.target = PC_ADD_NEW;
      end
      4'd2: begin
        c.asel = A_HEAD; c.wr = 1'b1; c.wsel = W_REF; c.act = ACT_POP;
        c.res = RES_SLOT_HEAD; c.done = 1'b1;
      end
      4'd3: begin
        c.cond = C_FULL; c.target = PC_FULL;
      end
      4'd4: begin
        c.asel = A_USED; c.wr = 1'b1; c.wsel = W_REF; c.act = ACT_INC_USED;
        c.res = RES_SLOT_USED; c.done = 1'b1;
      end
      4'd5: begin
        c.res = RES_FULL; c.done = 1'b1;
      end
      4'd6: begin
        c.cond = C_BAD; c.target = PC_BAD;
      end
      4'd7: begin
        c.asel = A_SLOT; c.wr = 1'b1; c.wsel = W_HEAD; c.act = ACT_PUSH; c.done = 1'b1;
      end
      4'd8: begin
        c.res = RES_BAD; c.done = 1'b1;
      end
      4'd9: begin
        c.asel = A_SLOT; c.rd = 1'b1; c.cond = C_BAD; c.target = PC_BAD;
      end
      4'd10: begin
        c.res = RES_WORD; c.done = 1'b1;
      end
      4'd11: begin
        c.cond = C_SKIP; c.target = PC_FINISH;
      end
      4'd12: begin
        c.asel = A_SCAN; c.rd = 1'b1; c.scan_inc = 1'b1;
      end
      4'd13: begin
        c.asel = A_SCAN; c.rd = 1'b1; c.scan_inc = 1'b1; c.res = RES_MATCH;
        c.cond = C_MORE; c.target = PC_SCAN;
      end
      default: begin
        c.done = 1'b1;
      end
    endcase
    return c;
  endfunction

endpackage

[rtl/otfl_mem.sv]
// single-port entry memory with registered read
module otfl_mem #(
  parameter int DEPTH = otfl_pkg::TABLE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic                       re,
  input  logic [AW-1:0]              addr,
  input  logic [otfl_pkg::REF_W-1:0] wdata,
  output logic [otfl_pkg::REF_W-1:0] rdata
);

  logic [otfl_pkg::REF_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[rtl/otfl_seq.sv]
// microprogram sequencer: step counter, control rom and conditional jumps
module otfl_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [1:0]                 op,
  input  otfl_pkg::flags_t           flags,
  output otfl_pkg::ctl_t             ctl,
  output logic                       busy
);

  logic [otfl_pkg::PC_W-1:0] pc;
  logic                      taken;

  assign ctl = busy ? otfl_pkg::ucode(pc) : '0;

  always_comb begin
    case (ctl.cond)
      otfl_pkg::C_HEAD_ZERO: taken = flags.head_zero;
      otfl_pkg::C_FULL:      taken = flags.full;
      otfl_pkg::C_BAD:       taken = flags.bad;
      otfl_pkg::C_SKIP:      taken = flags.skip;
      otfl_pkg::C_MORE:      taken = flags.more;
      default:               taken = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
    end else if (go) begin
      busy <= 1'b1;
      pc   <= otfl_pkg::entry_pc(op);
    end else if (busy) begin
      if (ctl.done) begin
        busy <= 1'b0;
      end
      pc <= taken ? ctl.target : pc + 1'b1;
    end
  end

endmodule

[rtl/object_table_free_list.sv]
// top level of the object table with free list
//
// Handle table of 64-bit object references; freed entries are chained into a
// free list. A word is taken when start is high and busy is low; busy stays
// high until the result, which appears on slot_out, word_out, found and status
// for exactly one cycle with done high and cannot be held off. contains compares
// at most used_count entries, as the scan stops at the first match, and skips
// the scan for a null reference or an empty table. Add, remove, lookup and
// contains run as microprogram steps around the single-port entry memory with
// its registered read, and contains scans one entry per cycle through that
// port. busy drops in the done cycle, so the next word can be taken there.
module object_table_free_list #(
  parameter int TABLE_DEPTH = otfl_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  op,
  input  logic [otfl_pkg::REF_W-1:0]  object_ref,
  input  logic [otfl_pkg::SLOT_W-1:0] slot,
  output logic                        done,
  output logic [otfl_pkg::SLOT_W-1:0] slot_out,
  output logic [otfl_pkg::REF_W-1:0]  word_out,
  output logic                        found,
  output logic [1:0]                  status
);

  localparam int CAP = (TABLE_DEPTH < otfl_pkg::SLOT_LIMIT) ? TABLE_DEPTH
                                                            : otfl_pkg::SLOT_LIMIT;
  localparam int AW  = $clog2(CAP);
  localparam logic [otfl_pkg::COUNT_W-1:0] CAP_C = otfl_pkg::COUNT_W'(CAP);

  logic                           go;
  otfl_pkg::ctl_t                 ctl;
  otfl_pkg::flags_t               flags;
  logic [otfl_pkg::REF_W-1:0]     ref_r;
  logic [otfl_pkg::SLOT_W-1:0]    slot_r;
  logic [otfl_pkg::COUNT_W-1:0]   used_count;
  logic [otfl_pkg::SLOT_W-1:0]    free_head;
  logic [otfl_pkg::COUNT_W-1:0]   scan;
  logic [AW-1:0]                  addr;
  logic [otfl_pkg::REF_W-1:0]     wdata;
  logic [otfl_pkg::REF_W-1:0]     rdata;
  logic                           we;
  logic                           head_ok;
  logic                           match;

  assign go      = start && !busy;
  assign head_ok = {1'b0, free_head} < CAP_C;
  assign match   = rdata == ref_r;

  assign flags.head_zero = free_head == '0;
  assign flags.full      = used_count >= CAP_C;
  assign flags.bad       = {1'b0, slot_r} >= used_count;
  assign flags.skip      = (ref_r == '0) || (used_count == '0);
  assign flags.more      = !match && (scan != used_count);

  always_comb begin
    case (ctl.asel)
      otfl_pkg::A_HEAD: addr = free_head[AW-1:0];
      otfl_pkg::A_SLOT: addr = slot_r[AW-1:0];
      otfl_pkg::A_USED: addr = used_count[AW-1:0];
      default:          addr = scan[AW-1:0];
    endcase
  end

  // entries past the table are neither written nor read back
  assign we    = ctl.wr && (ctl.asel != otfl_pkg::A_HEAD || head_ok);
  assign wdata = (ctl.wsel == otfl_pkg::W_HEAD)
                 ? otfl_pkg::REF_W'(free_head) : ref_r;

  otfl_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .go    (go),
    .op    (op),
    .flags (flags),
    .ctl   (ctl),
    .busy  (busy)
  );

  otfl_mem #(
    .DEPTH (CAP),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .re    (ctl.rd),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (go) begin
      ref_r  <= object_ref;
      slot_r <= slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
      free_head  <= '0;
    end else begin
      case (ctl.act)
        otfl_pkg::ACT_POP:      free_head  <= head_ok ? rdata[otfl_pkg::SLOT_W-1:0] : '0;
        otfl_pkg::ACT_PUSH:     free_head  <= slot_r;
        otfl_pkg::ACT_INC_USED: used_count <= used_count + 1'b1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      scan <= '0;
    end else if (ctl.scan_inc) begin
      scan <= scan + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.done;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      slot_out <= '0;
      word_out <= '0;
      found    <= 1'b0;
      status   <= otfl_pkg::ST_OK;
    end else begin
      case (ctl.res)
        otfl_pkg::RES_SLOT_HEAD: slot_out <= free_head;
        otfl_pkg::RES_SLOT_USED: slot_out <= used_count[otfl_pkg::SLOT_W-1:0];
        otfl_pkg::RES_WORD:      word_out <= rdata;
        otfl_pkg::RES_FULL:      status   <= otfl_pkg::ST_FULL;
        otfl_pkg::RES_BAD:       status   <= otfl_pkg::ST_BAD;
        otfl_pkg::RES_MATCH:     found    <= match;
        default: begin
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= CAP_C)
    else $error("used count beyond table capacity");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result word without an operation in flight");

  a_idle_state: assert property (@(posedge clk) disable iff (rst)
    !busy |=> $stable(free_head) && $stable(used_count))
    else $error("table state changed while idle");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    done && status != otfl_pkg::ST_OK |-> slot_out == '0 && word_out == '0 && !found)
    else $error("error result carries data");
`endif

endmodule

[sim/otfl_checker.sv]
`timescale 1ns / 1ps
// result checker for the object table free list: mirrors the table and compares each result word
module otfl_checker #(
  parameter int TABLE_DEPTH = otfl_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [1:0]                  op,
  input  logic [otfl_pkg::REF_W-1:0]  object_ref,
  input  logic [otfl_pkg::SLOT_W-1:0] slot,
  input  logic                        done,
  input  logic [otfl_pkg::SLOT_W-1:0] slot_out,
  input  logic [otfl_pkg::REF_W-1:0]  word_out,
  input  logic                        found,
  input  logic [1:0]                  status,
  output int                          mismatches,
  output int                          outstanding
);

  localparam int CAPACITY = (TABLE_DEPTH < otfl_pkg::SLOT_LIMIT) ? TABLE_DEPTH
                                                                 : otfl_pkg::SLOT_LIMIT;

  typedef struct packed {
    logic [otfl_pkg::SLOT_W-1:0] slot_out;
    logic [otfl_pkg::REF_W-1:0]  word_out;
    logic                        found;
    logic [1:0]                  status;
  } answer_t;

  logic [otfl_pkg::REF_W-1:0]   entry_words [otfl_pkg::SLOT_LIMIT];
  logic [otfl_pkg::COUNT_W-1:0] used_count;
  logic [otfl_pkg::SLOT_W-1:0]  free_head;
  answer_t                      expected_answers [$];
  answer_t                      oldest;

  function automatic answer_t apply_table_op(input logic [1:0] code,
                                             input logic [otfl_pkg::REF_W-1:0] obj,
                                             input logic [otfl_pkg::SLOT_W-1:0] idx);
    answer_t a;
    a = '0;
    case (code)
      otfl_pkg::OP_ADD: begin
        if (free_head != '0) begin
          a.slot_out = free_head;
          free_head = entry_words[free_head][otfl_pkg::SLOT_W-1:0];
          entry_words[a.slot_out] = obj;
        end else if (used_count >= CAPACITY) begin
          a.status = otfl_pkg::ST_FULL;
        end else begin
          a.slot_out = used_count[otfl_pkg::SLOT_W-1:0];
          entry_words[used_count[otfl_pkg::SLOT_W-1:0]] = obj;
          used_count = used_count + 1'b1;
        end
      end
      otfl_pkg::OP_REMOVE: begin
        if ({1'b0, idx} >= used_count) begin
          a.status = otfl_pkg::ST_BAD;
        end else begin
          entry_words[idx] = {{(otfl_pkg::REF_W-otfl_pkg::SLOT_W){1'b0}}, free_head};
          free_head = idx;
        end
      end
      otfl_pkg::OP_LOOKUP: begin
        if ({1'b0, idx} >= used_count) a.status = otfl_pkg::ST_BAD;
        else a.word_out = entry_words[idx];
      end
      default: begin
        if (obj != '0) begin
          for (int i = 0; i < int'(used_count); i++) begin
            if (entry_words[i] == obj) a.found = 1'b1;
          end
        end
      end
    endcase
    return a;
  endfunction

  task automatic report_mismatch(input string what, input logic [otfl_pkg::REF_W-1:0] got,
                                 input logic [otfl_pkg::REF_W-1:0] want);
    $display("%0t ns: %s got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      used_count = '0;
      free_head = '0;
      expected_answers.delete();
      mismatches = 0;
    end else begin
      if (done) begin
        if (expected_answers.size() == 0) begin
          report_mismatch("result word with none expected, status",
                          otfl_pkg::REF_W'(status), '0);
        end else begin
          oldest = expected_answers.pop_front();
          if (slot_out !== oldest.slot_out)
            report_mismatch("slot_out", otfl_pkg::REF_W'(slot_out),
                            otfl_pkg::REF_W'(oldest.slot_out));
          if (word_out !== oldest.word_out)
            report_mismatch("word_out", word_out, oldest.word_out);
          if (found !== oldest.found)
            report_mismatch("found", otfl_pkg::REF_W'(found), otfl_pkg::REF_W'(oldest.found));
          if (status !== oldest.status)
            report_mismatch("status", otfl_pkg::REF_W'(status),
                            otfl_pkg::REF_W'(oldest.status));
        end
      end
      if (start && !busy)
        expected_answers.insert(expected_answers.size(), apply_table_op(op, object_ref, slot));
    end
    outstanding = expected_answers.size();
  end

endmodule

[sim/tb_object_table_free_list.sv]
`timescale 1ns / 1ps
// testbench top for the object table free list: drives command words and gives the verdict
module tb_object_table_free_list;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int WORD_COUNT  = 1000;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic                        busy;
  logic [1:0]                  op = otfl_pkg::OP_ADD;
  logic [otfl_pkg::REF_W-1:0]  object_ref = '0;
  logic [otfl_pkg::SLOT_W-1:0] slot = '0;
  logic                        done;
  logic [otfl_pkg::SLOT_W-1:0] slot_out;
  logic [otfl_pkg::REF_W-1:0]  word_out;
  logic                        found;
  logic [1:0]                  status;
  int                          mismatches;
  int                          outstanding;
  int                          cycles = 0;
  int                          idle_pct = 28;

  // just enough of the table to keep every pop on an entry that was written
  int                          shadow_used = 0;
  int                          shadow_head = 0;
  logic [7:0]                  shadow_low [otfl_pkg::SLOT_LIMIT];
  logic [otfl_pkg::REF_W-1:0]  added_refs [$];

  object_table_free_list dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .object_ref(object_ref),
    .slot(slot), .done(done), .slot_out(slot_out), .word_out(word_out), .found(found),
    .status(status)
  );

  otfl_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .object_ref(object_ref),
    .slot(slot), .done(done), .slot_out(slot_out), .word_out(word_out), .found(found),
    .status(status), .mismatches(mismatches), .outstanding(outstanding)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [otfl_pkg::REF_W-1:0] pick_ref();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel < 3) return otfl_pkg::REF_W'($urandom_range(1, 20));
    if (sel < 5 && added_refs.size() != 0)
      return added_refs[$urandom_range(0, added_refs.size() - 1)];
    return {$urandom, $urandom};
  endfunction

  function automatic logic [otfl_pkg::SLOT_W-1:0] pick_slot();
    if (shadow_used != 0 && $urandom_range(0, 9) < 7)
      return otfl_pkg::SLOT_W'($urandom_range(0, shadow_used - 1));
    return otfl_pkg::SLOT_W'($urandom_range(0, 255));
  endfunction

  task automatic send_word(input logic [1:0] code, input logic [otfl_pkg::REF_W-1:0] obj,
                           input logic [otfl_pkg::SLOT_W-1:0] idx);
    logic [7:0] next_low;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    op <= code;
    object_ref <= obj;
    slot <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    case (code)
      otfl_pkg::OP_ADD: begin
        added_refs.insert(added_refs.size(), obj);
        if (added_refs.size() > 64) void'(added_refs.pop_front());
        if (shadow_head != 0) begin
          next_low = shadow_low[shadow_head];
          shadow_low[shadow_head] = obj[7:0];
          shadow_head = int'(next_low);
        end else if (shadow_used < otfl_pkg::SLOT_LIMIT) begin
          shadow_low[shadow_used] = obj[7:0];
          shadow_used++;
        end
      end
      otfl_pkg::OP_REMOVE: begin
        if (idx < shadow_used) begin
          shadow_low[idx] = 8'(shadow_head);
          shadow_head = int'(idx);
        end
      end
      default: ;
    endcase
  endtask

  initial begin
    int                          add_weight;
    int                          roll;
    logic [1:0]                  code;
    logic [otfl_pkg::SLOT_W-1:0] idx;
    add_weight = 45;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty table: null contains, miss, bad lookup and remove, then adds, lookups and contains
    send_word(otfl_pkg::OP_CONTAINS, '0, '0);
    send_word(otfl_pkg::OP_CONTAINS, {$urandom, $urandom} | 64'd1, 8'hFF);
    send_word(otfl_pkg::OP_LOOKUP, {$urandom, $urandom}, '0);
    send_word(otfl_pkg::OP_REMOVE, '0, 8'hFF);
    send_word(otfl_pkg::OP_ADD, '1, '0);
    send_word(otfl_pkg::OP_ADD, '0, 8'hFF);
    send_word(otfl_pkg::OP_ADD, 64'h8000_0000_0000_0001, '0);
    send_word(otfl_pkg::OP_ADD, 64'h5, '0);
    send_word(otfl_pkg::OP_LOOKUP, '0, 8'd0);
    send_word(otfl_pkg::OP_LOOKUP, '0, 8'd2);
    send_word(otfl_pkg::OP_LOOKUP, '0, 8'd3);
    send_word(otfl_pkg::OP_LOOKUP, '0, 8'd4);
    send_word(otfl_pkg::OP_CONTAINS, '1, '0);
    send_word(otfl_pkg::OP_CONTAINS, 64'h5, '0);
    // free words are compared like references
    send_word(otfl_pkg::OP_REMOVE, '0, 8'd2);
    send_word(otfl_pkg::OP_REMOVE, '0, 8'd3);
    send_word(otfl_pkg::OP_CONTAINS, 64'h2, '0);
    send_word(otfl_pkg::OP_LOOKUP, '0, 8'd3);
    send_word(otfl_pkg::OP_ADD, {$urandom, $urandom}, '0);
    // slot zero clears the list head
    send_word(otfl_pkg::OP_REMOVE, '0, 8'd0);
    send_word(otfl_pkg::OP_ADD, {$urandom, $urandom}, '0);
    // double remove, then pops follow the low byte of a stored reference
    send_word(otfl_pkg::OP_REMOVE, '0, 8'd1);
    send_word(otfl_pkg::OP_REMOVE, '0, 8'd1);
    send_word(otfl_pkg::OP_ADD, 64'h0123_4567_89AB_CD02, '0);
    send_word(otfl_pkg::OP_ADD, {$urandom, $urandom}, '0);
    send_word(otfl_pkg::OP_ADD, {$urandom, $urandom}, '0);

    for (int n = 0; n < WORD_COUNT; n++) begin
      if (n == WORD_COUNT / 3) idle_pct = 72;
      else if (n == 2 * WORD_COUNT / 3) idle_pct = 0;
      if (n % 50 == 0) begin
        roll = $urandom_range(0, 2);
        add_weight = (roll == 0) ? 25 : (roll == 1) ? 45 : 80;
      end
      if ($urandom_range(0, 99) < add_weight) begin
        code = otfl_pkg::OP_ADD;
      end else begin
        roll = $urandom_range(0, 9);
        code = (roll < 4) ? otfl_pkg::OP_REMOVE
             : (roll < 7) ? otfl_pkg::OP_LOOKUP : otfl_pkg::OP_CONTAINS;
      end
      idx = pick_slot();
      // a pop here would read an entry that was never written
      if (code == otfl_pkg::OP_ADD && shadow_head != 0 && shadow_head >= shadow_used) begin
        code = otfl_pkg::OP_REMOVE;
        idx = otfl_pkg::SLOT_W'($urandom_range(0, shadow_used - 1));
      end
      send_word(code, pick_ref(), idx);
    end

    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/otfl_pkg.sv
rtl/otfl_mem.sv
rtl/otfl_seq.sv
rtl/object_table_free_list.sv
sim/otfl_checker.sv
sim/tb_object_table_free_list.sv
